### hw/rtl/llbm_pkg.sv
// Package for the linked list buffer manager.
// Holds item types, operation and status codes and the store write-port struct.
// No dependencies.
`default_nettype none
package llbm_pkg;

	localparam int DEF_CAPACITY = 64;
	// Widest slot index the store port struct can carry (CAPACITY up to 8190).
	localparam int SLOT_MAXW = 13;

	localparam logic [3:0] FUNC_INS_HEAD   = 4'd0;
	localparam logic [3:0] FUNC_INS_TAIL   = 4'd1;
	localparam logic [3:0] FUNC_INS_AFTER  = 4'd2;
	localparam logic [3:0] FUNC_INS_SORTED = 4'd3;
	localparam logic [3:0] FUNC_DEL_HEAD   = 4'd4;
	localparam logic [3:0] FUNC_DEL_TAIL   = 4'd5;
	localparam logic [3:0] FUNC_DEL_SLOT   = 4'd6;
	localparam logic [3:0] FUNC_DEL_VALUE  = 4'd7;
	localparam logic [3:0] FUNC_FIND_FWD   = 4'd8;
	localparam logic [3:0] FUNC_FIND_BACK  = 4'd9;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_OVERFLOW  = 3'd1;
	localparam logic [2:0] ST_UNDERFLOW = 3'd2;
	localparam logic [2:0] ST_NOTFOUND  = 3'd3;
	localparam logic [2:0] ST_BADSLOT   = 3'd4;

	localparam logic signed [31:0] INT_MIN = 32'sh8000_0000;

	typedef struct packed {
		logic [3:0]         func;
		logic signed [31:0] value;
		logic [6:0]         location;
	} in_t;

	typedef struct packed {
		logic signed [31:0] result_value;
		logic [6:0]         result_location;
		logic [2:0]         status;
	} out_t;

	typedef struct packed {
		logic                 next_we;
		logic [SLOT_MAXW-1:0] next_addr;
		logic [SLOT_MAXW-1:0] next_data;
		logic                 prev_we;
		logic [SLOT_MAXW-1:0] prev_addr;
		logic [SLOT_MAXW-1:0] prev_data;
		logic                 val_we;
		logic [SLOT_MAXW-1:0] val_addr;
		logic signed [31:0]   val_data;
		logic                 inl_we;
		logic [SLOT_MAXW-1:0] inl_addr;
		logic                 inl_data;
	} wr_t;

endpackage
`default_nettype wire

### hw/rtl/linked_list_buffer_manager_core.sv
// Top level of the linked list buffer manager.
// Depends on llbm_pkg and llbm_store.
`default_nettype none
// A circular doubly linked list kept in slot stores, with a sentinel at slot 0
// and a free chain of slots 1 to CAPACITY. After reset the block sweeps the
// stores, slots 0 to CAPACITY, and is not ready meanwhile. Each item is one
// operation and yields one result item. A small sequencer drives the single
// read port of the slot store. Sorted insert, delete by value and the searches
// walk the list and visit up to CAPACITY entries. A finished result sits in
// an output register, so the next item can be taken while it waits.
module linked_list_buffer_manager_core #(
	parameter int CAPACITY = llbm_pkg::DEF_CAPACITY
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire llbm_pkg::in_t  in_data,
	output logic                out_valid,
	input  wire logic           out_ready,
	output llbm_pkg::out_t      out_data
);

	localparam int IW = $clog2(CAPACITY + 2);
	localparam logic [IW-1:0] CAP_I = IW'(CAPACITY);
	localparam logic [31:0] CAP_32 = 32'(CAPACITY);

	localparam logic [3:0] S_CLR  = 4'd0;
	localparam logic [3:0] S_IDLE = 4'd1;
	localparam logic [3:0] S_RD0  = 4'd2;
	localparam logic [3:0] S_DEC  = 4'd3;
	localparam logic [3:0] S_CHK  = 4'd4;
	localparam logic [3:0] S_WA   = 4'd5;
	localparam logic [3:0] S_WB   = 4'd6;
	localparam logic [3:0] S_WE   = 4'd7;
	localparam logic [3:0] S_L1   = 4'd8;
	localparam logic [3:0] S_L2   = 4'd9;
	localparam logic [3:0] S_L3   = 4'd10;
	localparam logic [3:0] S_L4   = 4'd11;
	localparam logic [3:0] S_U1   = 4'd12;
	localparam logic [3:0] S_U2   = 4'd13;
	localparam logic [3:0] S_U3   = 4'd14;
	localparam logic [3:0] S_FIN  = 4'd15;

	logic [3:0]         state_q;
	logic [IW-1:0]      clr_q;
	logic [3:0]         func_q;
	logic signed [31:0] val_q;
	logic [6:0]         loc_q;
	logic [IW-1:0]      free_q;
	logic [IW-1:0]      nf_q;
	logic [IW-1:0]      cur_q;
	logic [IW-1:0]      tgt_q;
	logic [IW-1:0]      after_q;
	logic [IW-1:0]      steps_q;
	logic               found_q;
	logic signed [31:0] rv_q;
	logic [6:0]         rl_q;
	logic [2:0]         st_q;
	logic               out_valid_q;
	llbm_pkg::out_t     out_q;

	llbm_pkg::wr_t      wr;
	logic [IW-1:0]      raddr;
	logic [IW-1:0]      rd_next;
	logic [IW-1:0]      rd_prev;
	logic signed [31:0] rd_val;
	logic               rd_inl;
	logic               loc_ok;
	logic               free_empty;
	logic               in_acc;
	logic               fwd;

	llbm_store #(.CAPACITY(CAPACITY)) u_store (
		.clk     (clk),
		.wr      (wr),
		.raddr   (raddr),
		.rd_next (rd_next),
		.rd_prev (rd_prev),
		.rd_val  (rd_val),
		.rd_inl  (rd_inl)
	);

	assign loc_ok     = (32'(loc_q) <= CAP_32);
	assign free_empty = (free_q == '0) || (free_q > CAP_I);
	assign in_ready   = (state_q == S_IDLE);
	assign in_acc     = in_valid && in_ready;
	assign out_valid  = out_valid_q;
	assign out_data   = out_q;
	assign fwd        = (func_q != llbm_pkg::FUNC_FIND_BACK);

	always_comb begin
		unique case (state_q)
			S_DEC:        raddr = loc_ok ? IW'(loc_q) : '0;
			S_WA:         raddr = cur_q;
			S_L1:         raddr = free_q;
			S_L2, S_U1:   raddr = tgt_q;
			default:      raddr = '0;
		endcase
	end

	always_comb begin
		wr = '0;
		unique case (state_q)
			S_CLR: begin
				wr.next_we   = 1'b1;
				wr.next_addr = llbm_pkg::SLOT_MAXW'(clr_q);
				wr.next_data = (clr_q == '0) ? '0 : llbm_pkg::SLOT_MAXW'(clr_q + 1'b1);
				wr.prev_we   = 1'b1;
				wr.prev_addr = llbm_pkg::SLOT_MAXW'(clr_q);
				wr.val_we    = 1'b1;
				wr.val_addr  = llbm_pkg::SLOT_MAXW'(clr_q);
				wr.inl_we    = 1'b1;
				wr.inl_addr  = llbm_pkg::SLOT_MAXW'(clr_q);
			end
			S_L3: begin
				// New slot takes the free head, linked between tgt and its successor.
				wr.next_we   = 1'b1;
				wr.next_addr = llbm_pkg::SLOT_MAXW'(free_q);
				wr.next_data = llbm_pkg::SLOT_MAXW'(rd_next);
				wr.prev_we   = 1'b1;
				wr.prev_addr = llbm_pkg::SLOT_MAXW'(free_q);
				wr.prev_data = llbm_pkg::SLOT_MAXW'(tgt_q);
				wr.val_we    = 1'b1;
				wr.val_addr  = llbm_pkg::SLOT_MAXW'(free_q);
				wr.val_data  = val_q;
				wr.inl_we    = 1'b1;
				wr.inl_addr  = llbm_pkg::SLOT_MAXW'(free_q);
				wr.inl_data  = 1'b1;
			end
			S_L4: begin
				wr.next_we   = 1'b1;
				wr.next_addr = llbm_pkg::SLOT_MAXW'(tgt_q);
				wr.next_data = llbm_pkg::SLOT_MAXW'(free_q);
				wr.prev_we   = 1'b1;
				wr.prev_addr = llbm_pkg::SLOT_MAXW'(after_q);
				wr.prev_data = llbm_pkg::SLOT_MAXW'(free_q);
			end
			S_U2: begin
				wr.next_we   = 1'b1;
				wr.next_addr = llbm_pkg::SLOT_MAXW'(tgt_q);
				wr.next_data = llbm_pkg::SLOT_MAXW'(free_q);
				wr.inl_we    = 1'b1;
				wr.inl_addr  = llbm_pkg::SLOT_MAXW'(tgt_q);
			end
			S_U3: begin
				// cur_q holds the predecessor and after_q the successor.
				wr.next_we   = 1'b1;
				wr.next_addr = llbm_pkg::SLOT_MAXW'(cur_q);
				wr.next_data = llbm_pkg::SLOT_MAXW'(after_q);
				wr.prev_we   = 1'b1;
				wr.prev_addr = llbm_pkg::SLOT_MAXW'(after_q);
				wr.prev_data = llbm_pkg::SLOT_MAXW'(cur_q);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			clr_q       <= '0;
			free_q      <= IW'(1);
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && state_q != S_FIN) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == CAP_I) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_acc) begin
						func_q  <= in_data.func;
						val_q   <= in_data.value;
						loc_q   <= in_data.location;
						rv_q    <= '0;
						rl_q    <= '0;
						st_q    <= llbm_pkg::ST_OK;
						state_q <= S_RD0;
					end
				end
				S_RD0: begin
					state_q <= S_DEC;
				end
				S_DEC: begin
					cur_q   <= (func_q == llbm_pkg::FUNC_FIND_BACK) ? rd_prev : rd_next;
					steps_q <= '0;
					found_q <= 1'b0;
					case (func_q) inside
						llbm_pkg::FUNC_INS_HEAD, llbm_pkg::FUNC_INS_TAIL,
						llbm_pkg::FUNC_INS_AFTER, llbm_pkg::FUNC_INS_SORTED: begin
							if (free_empty) begin
								st_q    <= llbm_pkg::ST_OVERFLOW;
								state_q <= S_FIN;
							end else if (func_q == llbm_pkg::FUNC_INS_HEAD) begin
								tgt_q   <= '0;
								state_q <= S_L1;
							end else if (func_q == llbm_pkg::FUNC_INS_TAIL) begin
								tgt_q   <= rd_prev;
								state_q <= S_L1;
							end else if (func_q == llbm_pkg::FUNC_INS_AFTER) begin
								if (!loc_ok) begin
									st_q    <= llbm_pkg::ST_BADSLOT;
									state_q <= S_FIN;
								end else if (loc_q == '0) begin
									tgt_q   <= '0;
									state_q <= S_L1;
								end else begin
									state_q <= S_CHK;
								end
							end else begin
								tgt_q   <= '0;
								state_q <= S_WA;
							end
						end
						llbm_pkg::FUNC_DEL_HEAD, llbm_pkg::FUNC_DEL_TAIL,
						llbm_pkg::FUNC_DEL_SLOT, llbm_pkg::FUNC_DEL_VALUE: begin
							rv_q <= llbm_pkg::INT_MIN;
							if (rd_next == '0) begin
								st_q    <= llbm_pkg::ST_UNDERFLOW;
								state_q <= S_FIN;
							end else if (func_q == llbm_pkg::FUNC_DEL_HEAD) begin
								tgt_q   <= rd_next;
								state_q <= S_U1;
							end else if (func_q == llbm_pkg::FUNC_DEL_TAIL) begin
								tgt_q   <= rd_prev;
								state_q <= S_U1;
							end else if (func_q == llbm_pkg::FUNC_DEL_SLOT) begin
								if (!loc_ok || loc_q == '0) begin
									st_q    <= llbm_pkg::ST_BADSLOT;
									state_q <= S_FIN;
								end else begin
									state_q <= S_CHK;
								end
							end else begin
								state_q <= S_WA;
							end
						end
						llbm_pkg::FUNC_FIND_FWD, llbm_pkg::FUNC_FIND_BACK: begin
							state_q <= S_WA;
						end
						default: begin
							state_q <= S_FIN;
						end
					endcase
				end
				S_CHK: begin
					tgt_q <= IW'(loc_q);
					if (!rd_inl) begin
						st_q    <= llbm_pkg::ST_BADSLOT;
						state_q <= S_FIN;
					end else if (func_q == llbm_pkg::FUNC_INS_AFTER) begin
						state_q <= S_L1;
					end else begin
						state_q <= S_U1;
					end
				end
				S_WA: begin
					if (cur_q == '0 || steps_q == CAP_I) begin
						state_q <= S_WE;
					end else begin
						state_q <= S_WB;
					end
				end
				S_WB: begin
					if (func_q == llbm_pkg::FUNC_INS_SORTED) begin
						// Sorted insert goes before the first strictly greater entry.
						if (val_q < rd_val) begin
							state_q <= S_WE;
						end else begin
							tgt_q   <= cur_q;
							cur_q   <= rd_next;
							steps_q <= steps_q + 1'b1;
							state_q <= S_WA;
						end
					end else if (rd_val == val_q) begin
						found_q <= 1'b1;
						state_q <= S_WE;
					end else begin
						cur_q   <= fwd ? rd_next : rd_prev;
						steps_q <= steps_q + 1'b1;
						state_q <= S_WA;
					end
				end
				S_WE: begin
					if (func_q == llbm_pkg::FUNC_INS_SORTED) begin
						state_q <= S_L1;
					end else if (!found_q) begin
						st_q    <= llbm_pkg::ST_NOTFOUND;
						state_q <= S_FIN;
					end else if (func_q == llbm_pkg::FUNC_DEL_VALUE) begin
						tgt_q   <= cur_q;
						state_q <= S_U1;
					end else begin
						rl_q    <= 7'(cur_q);
						state_q <= S_FIN;
					end
				end
				S_L1: begin
					state_q <= S_L2;
				end
				S_L2: begin
					nf_q    <= rd_next;
					state_q <= S_L3;
				end
				S_L3: begin
					after_q <= rd_next;
					state_q <= S_L4;
				end
				S_L4: begin
					rl_q    <= 7'(free_q);
					free_q  <= nf_q;
					state_q <= S_FIN;
				end
				S_U1: begin
					state_q <= S_U2;
				end
				S_U2: begin
					cur_q   <= rd_prev;
					after_q <= rd_next;
					rv_q    <= rd_val;
					state_q <= S_U3;
				end
				S_U3: begin
					rl_q    <= 7'(tgt_q);
					free_q  <= tgt_q;
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (!out_valid_q || out_ready) begin
						out_q.result_value    <= rv_q;
						out_q.result_location <= rl_q;
						out_q.status          <= st_q;
						out_valid_q           <= 1'b1;
						state_q               <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// The free head is never slot 0 once the sweep is done.
	a_free_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_CLR) |-> (free_q != '0))
		else $error("free head points at the sentinel");

	// An accepted item keeps the block busy in the next cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !in_ready)
		else $error("ready right after accepting an item");

	// A list walk never runs past CAPACITY steps.
	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WB) |-> (steps_q < CAP_I))
		else $error("list walk exceeded its step bound");

endmodule
`default_nettype wire

### hw/rtl/llbm_store.sv
// Slot store of the linked list buffer manager: forward link, backward link,
// value and in-list bit per slot, one shared read address, registered read data.
// Depends on llbm_pkg.
`default_nettype none
module llbm_store #(
	parameter int CAPACITY = llbm_pkg::DEF_CAPACITY,
	localparam int IW = $clog2(CAPACITY + 2)
) (
	input  wire logic               clk,
	input  wire llbm_pkg::wr_t      wr,
	input  wire logic [IW-1:0]      raddr,
	output logic [IW-1:0]           rd_next,
	output logic [IW-1:0]           rd_prev,
	output logic signed [31:0]      rd_val,
	output logic                    rd_inl
);

	logic [IW-1:0]      next_mem [CAPACITY+1];
	logic [IW-1:0]      prev_mem [CAPACITY+1];
	logic signed [31:0] val_mem  [CAPACITY+1];
	logic               inl_mem  [CAPACITY+1];

	always_ff @(posedge clk) begin
		if (wr.next_we) begin
			next_mem[wr.next_addr[IW-1:0]] <= wr.next_data[IW-1:0];
		end
		if (wr.prev_we) begin
			prev_mem[wr.prev_addr[IW-1:0]] <= wr.prev_data[IW-1:0];
		end
		if (wr.val_we) begin
			val_mem[wr.val_addr[IW-1:0]] <= wr.val_data;
		end
		if (wr.inl_we) begin
			inl_mem[wr.inl_addr[IW-1:0]] <= wr.inl_data;
		end
		rd_next <= next_mem[raddr];
		rd_prev <= prev_mem[raddr];
		rd_val  <= val_mem[raddr];
		rd_inl  <= inl_mem[raddr];
	end

endmodule
`default_nettype wire
